### hw/rtl/pdsf_pkg.sv
// Shared types and constants for the PID duty servo frame block.
package pdsf_pkg;

    localparam int ADC_BITS_DEF       = 12;
    localparam int GAIN_FRAC_BITS_DEF = 12;

    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 14;
    localparam int ID_W       = 7;
    localparam int BYTE_W     = 8;
    localparam int INTEG_W    = 32;
    localparam int SUM_W      = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 2;
    localparam int OUT_W      = 24;

    localparam logic [BYTE_W-1:0] FRAME_START = 8'h80;
    localparam logic [BYTE_W-1:0] FRAME_CMD   = 8'h04;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd819;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd4301;
    localparam logic [DUTY_W-1:0]        DUTY_LOW_RST  = 14'd1600;
    localparam logic [DUTY_W-1:0]        DUTY_HIGH_RST = 14'd4000;
    localparam logic [DUTY_W-1:0]        DUTY_RST      = 14'd2500;
    localparam logic [ID_W-1:0]          DEVICE_ID_RST = 7'd1;
    localparam logic [ID_W-1:0]          SERVO_RST     = 7'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_DUTY_LOW  = 3'd3,
        REG_DUTY_HIGH = 3'd4,
        REG_DEVICE_ID = 3'd5,
        REG_SERVO     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [DUTY_W-1:0]        duty_low;
        logic [DUTY_W-1:0]        duty_high;
        logic [ID_W-1:0]          device_id;
        logic [ID_W-1:0]          servo_number;
    } t_cfg;

    // one queued frame request
    typedef struct packed {
        logic              valid;
        logic [DUTY_W-1:0] duty;
    } t_duty_req;

endpackage

### hw/rtl/pdsf_front.sv
// Front end: error, PID terms, integral and duty update, pushes duty requests.
module pdsf_front #(
    parameter int ADC_BITS       = pdsf_pkg::ADC_BITS_DEF,
    parameter int GAIN_FRAC_BITS = pdsf_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdsf_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ADC_BITS-1:0] i_target,
    input  logic [ADC_BITS-1:0] i_measured,
    input  logic                i_full,
    output pdsf_pkg::t_duty_req o_push
);
    localparam int ERR_W = ADC_BITS + 1;
    localparam int DIF_W = ADC_BITS + 2;
    localparam int P_W   = pdsf_pkg::GAIN_W + ERR_W;
    localparam int D_W   = pdsf_pkg::GAIN_W + DIF_W;
    localparam int SUM_W = pdsf_pkg::SUM_W;
    localparam logic signed [P_W-1:0] P_BIAS = P_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam logic signed [D_W-1:0] D_BIAS = D_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam logic signed [SUM_W-1:0] I_MAX =
        {{(SUM_W-pdsf_pkg::INTEG_W+1){1'b0}}, {(pdsf_pkg::INTEG_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] I_MIN =
        {{(SUM_W-pdsf_pkg::INTEG_W+1){1'b1}}, {(pdsf_pkg::INTEG_W-1){1'b0}}};

    logic adv;

    // stage 1: error and error delta
    logic                    r_v1;
    logic signed [ERR_W-1:0] r_err;
    logic signed [DIF_W-1:0] r_diff;
    logic signed [ERR_W-1:0] r_prev;
    logic signed [ERR_W-1:0] n_err;

    // stage 2: raw products
    logic                  r_v2;
    logic signed [P_W-1:0] r_prod_p;
    logic signed [P_W-1:0] r_prod_i;
    logic signed [D_W-1:0] r_prod_d;

    // stage 3: p+d and the running integral
    logic                                    r_v3;
    logic signed [SUM_W-1:0]                 r_pd;
    logic signed [pdsf_pkg::INTEG_W-1:0]     r_integ;
    logic signed [P_W-1:0]                   t_p;
    logic signed [P_W-1:0]                   t_i;
    logic signed [D_W-1:0]                   t_d;
    logic signed [SUM_W-1:0]                 isum;
    logic signed [SUM_W-1:0]                 n_integ;

    logic [pdsf_pkg::DUTY_W-1:0] r_duty;
    logic signed [SUM_W-1:0]     dsum;
    logic [pdsf_pkg::DUTY_W-1:0] n_duty;

    assign adv     = !r_v3 || !i_full;
    assign o_ready = adv;
    assign n_err   = $signed({1'b0, i_target}) - $signed({1'b0, i_measured});

    always_comb begin
        t_p = (r_prod_p[P_W-1] ? r_prod_p + P_BIAS : r_prod_p) >>> GAIN_FRAC_BITS;
        t_i = (r_prod_i[P_W-1] ? r_prod_i + P_BIAS : r_prod_i) >>> GAIN_FRAC_BITS;
        t_d = (r_prod_d[D_W-1] ? r_prod_d + D_BIAS : r_prod_d) >>> GAIN_FRAC_BITS;
        isum = SUM_W'(r_integ) + SUM_W'(t_i);
        if (isum > I_MAX) begin
            n_integ = I_MAX;
        end else if (isum < I_MIN) begin
            n_integ = I_MIN;
        end else begin
            n_integ = isum;
        end
    end

    // duty update with low bound taking priority
    always_comb begin
        dsum = $signed(SUM_W'(r_duty)) + r_pd + SUM_W'(r_integ);
        if (dsum < $signed(SUM_W'(i_cfg.duty_low))) begin
            n_duty = i_cfg.duty_low;
        end else if (dsum > $signed(SUM_W'(i_cfg.duty_high))) begin
            n_duty = i_cfg.duty_high;
        end else begin
            n_duty = dsum[pdsf_pkg::DUTY_W-1:0];
        end
    end

    assign o_push.valid = r_v3 && !i_full;
    assign o_push.duty  = n_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_prev  <= '0;
            r_integ <= '0;
            r_duty  <= pdsf_pkg::DUTY_RST;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_valid) begin
                r_prev <= n_err;
            end
            if (r_v2) begin
                r_integ <= n_integ[pdsf_pkg::INTEG_W-1:0];
            end
            if (r_v3) begin
                r_duty <= n_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_err    <= n_err;
            r_diff   <= DIF_W'(n_err) - DIF_W'(r_prev);
            r_prod_p <= i_cfg.gain_p * r_err;
            r_prod_i <= i_cfg.gain_i * r_err;
            r_prod_d <= i_cfg.gain_d * r_diff;
            r_pd     <= SUM_W'(t_p) + SUM_W'(t_d);
        end
    end

    a_duty_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && (i_cfg.duty_low <= i_cfg.duty_high))
        |-> (o_push.duty >= i_cfg.duty_low && o_push.duty <= i_cfg.duty_high))
        else $error("duty outside clamp window");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_full) |=> (r_v3 && $stable(r_pd)))
        else $error("stalled stage 3 lost its item");

endmodule

### hw/rtl/pdsf_fifo.sv
// Short queue of duty requests between front and back.
module pdsf_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdsf_pkg::t_duty_req i_push,
    output logic                o_full,
    input  logic                i_pop,
    output pdsf_pkg::t_duty_req o_head
);
    localparam int DEPTH = pdsf_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [pdsf_pkg::DUTY_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]            r_wr;
    logic [PTR_W-1:0]            r_rd;
    logic [CNT_W-1:0]            r_count;
    logic                        push;
    logic                        pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign push         = i_push.valid && !o_full;
    assign pop          = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.duty  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.duty;
        end
    end

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("push into full queue");

endmodule

### hw/rtl/pdsf_back.sv
// Back end: serializes one duty request into a six-byte command frame.
module pdsf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdsf_pkg::t_cfg      i_cfg,
    input  pdsf_pkg::t_duty_req i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last,
    output logic [13:0]         o_duty
);
    typedef enum logic [2:0] {
        S_START, S_DEV, S_CMD, S_SERVO, S_DUTY_HI, S_DUTY_LO
    } t_slot;

    t_slot                       r_slot;
    logic                        r_have;
    logic [pdsf_pkg::DUTY_W-1:0] r_duty;
    logic                        xfer;
    logic                        done;

    assign xfer    = r_have && i_ready;
    assign done    = xfer && (r_slot == S_DUTY_LO);
    assign o_pop   = i_head.valid && (!r_have || done);
    assign o_valid = r_have;
    assign o_last  = (r_slot == S_DUTY_LO);
    assign o_duty  = r_duty;

    always_comb begin
        case (r_slot)
            S_START:   o_byte = pdsf_pkg::FRAME_START;
            S_DEV:     o_byte = {1'b0, i_cfg.device_id};
            S_CMD:     o_byte = pdsf_pkg::FRAME_CMD;
            S_SERVO:   o_byte = {1'b0, i_cfg.servo_number};
            S_DUTY_HI: o_byte = {1'b0, r_duty[pdsf_pkg::DUTY_W-1:7]};
            S_DUTY_LO: o_byte = {1'b0, r_duty[6:0]};
            default:   o_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= S_START;
            r_have <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
                r_slot <= S_START;
                r_duty <= i_head.duty;
            end else if (done) begin
                r_have <= 1'b0;
                r_slot <= S_START;
            end else if (xfer) begin
                case (r_slot)
                    S_START:   r_slot <= S_DEV;
                    S_DEV:     r_slot <= S_CMD;
                    S_CMD:     r_slot <= S_SERVO;
                    S_SERVO:   r_slot <= S_DUTY_HI;
                    S_DUTY_HI: r_slot <= S_DUTY_LO;
                    default:   r_slot <= S_START;
                endcase
            end
        end
    end

    a_idle_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !i_head.valid) |=> !r_have)
        else $error("frame not closed after last byte");

    a_duty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_have && !done) |=> $stable(r_duty))
        else $error("duty changed inside a frame");

endmodule

### hw/rtl/pid_duty_servo_frame.sv
// Top level of the incremental PID servo controller with command frame output.
//
// Usage:
//   Input stream (i_s_*): one transfer carries a target and a measured
//   ADC code. Each accepted item updates the PID state (error history,
//   saturating integral, clamped duty) and produces one six-byte command
//   frame: 0x80, device id, 0x04, servo number, duty[13:7], duty[6:0].
//   Output stream (o_m_*): one byte per transfer, tlast on the sixth byte,
//   the updated duty carried alongside every byte of the frame.
//   Config port (i_cfg_*): register writes by index, always ready; write
//   only while the block is idle.
// Path: the first frame byte follows the input transfer through the front
//   stages, the queue write and the frame load.
// Throughput: the back end serializer sends one byte per cycle while the
//   receiver is ready; frames follow without a gap while the queue holds one.
//   The front accepts one item per cycle until the two-entry queue fills.
// Reset: synchronous, active low; registers return to their defaults,
//   duty to 2500, integral and previous error to zero.
// Stall: when the receiver holds tready low the current byte holds, the
//   queue and then the front stages fill, and o_s_tready drops.
module pid_duty_servo_frame #(
    parameter int ADC_BITS       = pdsf_pkg::ADC_BITS_DEF,
    parameter int GAIN_FRAC_BITS = pdsf_pkg::GAIN_FRAC_BITS_DEF,
    localparam int IN_W          = ((2 * ADC_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [IN_W-1:0]                    i_s_tdata,   // target, measured
    // output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [pdsf_pkg::OUT_W-1:0]         o_m_tdata,   // tx_byte, duty_now
    output logic                               o_m_tlast,   // last_byte
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pdsf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pdsf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    pdsf_pkg::t_cfg      r_cfg;
    pdsf_pkg::t_duty_req push;
    pdsf_pkg::t_duty_req head;
    logic                q_full;
    logic                q_pop;
    logic [7:0]          tx_byte;
    logic [13:0]         duty_now;

    assign o_cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p       <= pdsf_pkg::GAIN_P_RST;
            r_cfg.gain_i       <= pdsf_pkg::GAIN_I_RST;
            r_cfg.gain_d       <= pdsf_pkg::GAIN_D_RST;
            r_cfg.duty_low     <= pdsf_pkg::DUTY_LOW_RST;
            r_cfg.duty_high    <= pdsf_pkg::DUTY_HIGH_RST;
            r_cfg.device_id    <= pdsf_pkg::DEVICE_ID_RST;
            r_cfg.servo_number <= pdsf_pkg::SERVO_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pdsf_pkg::REG_GAIN_P:    r_cfg.gain_p       <= $signed(i_cfg_data);
                pdsf_pkg::REG_GAIN_I:    r_cfg.gain_i       <= $signed(i_cfg_data);
                pdsf_pkg::REG_GAIN_D:    r_cfg.gain_d       <= $signed(i_cfg_data);
                pdsf_pkg::REG_DUTY_LOW:  r_cfg.duty_low     <= i_cfg_data[13:0];
                pdsf_pkg::REG_DUTY_HIGH: r_cfg.duty_high    <= i_cfg_data[13:0];
                pdsf_pkg::REG_DEVICE_ID: r_cfg.device_id    <= i_cfg_data[6:0];
                pdsf_pkg::REG_SERVO:     r_cfg.servo_number <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    pdsf_front #(
        .ADC_BITS       (ADC_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_target    (i_s_tdata[ADC_BITS-1:0]),
        .i_measured  (i_s_tdata[2*ADC_BITS-1:ADC_BITS]),
        .i_full      (q_full),
        .o_push      (push)
    );

    pdsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (head)
    );

    pdsf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .o_pop   (q_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (tx_byte),
        .o_last  (o_m_tlast),
        .o_duty  (duty_now)
    );

    assign o_m_tdata = {2'b00, duty_now, tx_byte};

endmodule

### tb/pid_duty_servo_frame_test.sv
// Self-checking testbench for the PID duty servo frame block.
`timescale 1ns / 100ps

module pid_duty_servo_frame_test;

    localparam int IN_W = ((2 * pdsf_pkg::ADC_BITS_DEF + 7) / 8) * 8;

    // register index the block does not decode; writes to it must be dropped
    localparam logic [pdsf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint INTEG_MAX = (longint'(1) <<< (pdsf_pkg::INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN = -(longint'(1) <<< (pdsf_pkg::INTEG_W - 1));

    // one byte of a command frame as it should leave the block
    typedef struct {
        logic [pdsf_pkg::BYTE_W-1:0] tx_byte;
        logic                        last_byte;
        logic [pdsf_pkg::DUTY_W-1:0] duty_now;
    } t_frame_byte;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [IN_W-1:0]                 i_s_tdata = '0;      // target, measured
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [pdsf_pkg::OUT_W-1:0]      o_m_tdata;           // tx_byte, duty_now
    logic                            o_m_tlast;           // last_byte
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [pdsf_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pdsf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    pid_duty_servo_frame i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller model: own copy of the registers and the loop state.
    // ------------------------------------------------------------------
    pdsf_pkg::t_cfg ctl_cfg = '{pdsf_pkg::GAIN_P_RST, pdsf_pkg::GAIN_I_RST,
                                pdsf_pkg::GAIN_D_RST, pdsf_pkg::DUTY_LOW_RST,
                                pdsf_pkg::DUTY_HIGH_RST, pdsf_pkg::DEVICE_ID_RST,
                                pdsf_pkg::SERVO_RST};
    logic [pdsf_pkg::DUTY_W-1:0] duty_reg = pdsf_pkg::DUTY_RST;
    longint                      prev_err = 0;
    longint                      integ_acc = 0;

    t_frame_byte pending_bytes[$];   // frame bytes still owed by the block
    t_frame_byte want_byte;
    int          mismatch_cnt = 0;

    int gap_pct = 0;      // chance per cycle that the input side sits idle
    int stall_pct = 0;    // chance per cycle that the output side holds off
    int hold_left = 0;    // cycles of forced output hold still to run

    // gain * x in Q4.12, truncated toward zero
    function automatic longint scale_q12(input longint gain, input longint x);
        longint prod;
        prod = gain * x;
        if (prod < 0)
            return -((-prod) >>> pdsf_pkg::GAIN_FRAC_BITS_DEF);
        return prod >>> pdsf_pkg::GAIN_FRAC_BITS_DEF;
    endfunction

    // one control update; queues the six bytes of the resulting frame
    task automatic predict_frame(input logic [11:0] sp, input logic [11:0] mv);
        longint                      sp_l, mv_l, err, acc, duty, lo, hi;
        logic [pdsf_pkg::DUTY_W-1:0] dn;
        logic [pdsf_pkg::BYTE_W-1:0] frame [6];
        int                          k;
        sp_l = sp;
        mv_l = mv;
        err  = sp_l - mv_l;
        acc  = integ_acc + scale_q12($signed(ctl_cfg.gain_i), err);
        if (acc > INTEG_MAX)
            acc = INTEG_MAX;
        if (acc < INTEG_MIN)
            acc = INTEG_MIN;
        integ_acc = acc;
        duty = duty_reg;
        duty = duty + scale_q12($signed(ctl_cfg.gain_p), err) + integ_acc
             + scale_q12($signed(ctl_cfg.gain_d), err - prev_err);
        lo = ctl_cfg.duty_low;
        hi = ctl_cfg.duty_high;
        // low bound wins when the bounds cross
        if (duty < lo)
            duty = lo;
        else if (duty > hi)
            duty = hi;
        dn       = duty[pdsf_pkg::DUTY_W-1:0];
        duty_reg = dn;
        prev_err = err;
        frame = '{pdsf_pkg::FRAME_START, {1'b0, ctl_cfg.device_id}, pdsf_pkg::FRAME_CMD,
                  {1'b0, ctl_cfg.servo_number}, {1'b0, dn[13:7]}, {1'b0, dn[6:0]}};
        for (k = 0; k < 6; k++)
            pending_bytes.push_back('{frame[k], (k == 5), dn});
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one sample; tvalid is left high after the transfer so that a
    // following call can keep it up. Anything that lets time pass after the
    // last sample must drop it first.
    task automatic send_sample(input logic [11:0] sp, input logic [11:0] mv);
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {mv, sp};
        do @(posedge i_clk); while (!o_s_tready);
        predict_frame(sp, mv);
    endtask

    // register write; valid stays high for back-to-back writes
    task automatic write_reg(input logic [pdsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pdsf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (pdsf_pkg::t_reg_idx'(idx))
            pdsf_pkg::REG_GAIN_P:    ctl_cfg.gain_p       = data;
            pdsf_pkg::REG_GAIN_I:    ctl_cfg.gain_i       = data;
            pdsf_pkg::REG_GAIN_D:    ctl_cfg.gain_d       = data;
            pdsf_pkg::REG_DUTY_LOW:  ctl_cfg.duty_low     = data[pdsf_pkg::DUTY_W-1:0];
            pdsf_pkg::REG_DUTY_HIGH: ctl_cfg.duty_high    = data[pdsf_pkg::DUTY_W-1:0];
            pdsf_pkg::REG_DEVICE_ID: ctl_cfg.device_id    = data[pdsf_pkg::ID_W-1:0];
            pdsf_pkg::REG_SERVO:     ctl_cfg.servo_number = data[pdsf_pkg::ID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input int gp, input int gi, input int gd, input int lo,
                               input int hi, input int id, input int sv);
        write_reg(pdsf_pkg::REG_GAIN_P,    pdsf_pkg::CFG_DATA_W'(gp));
        write_reg(pdsf_pkg::REG_GAIN_I,    pdsf_pkg::CFG_DATA_W'(gi));
        write_reg(pdsf_pkg::REG_GAIN_D,    pdsf_pkg::CFG_DATA_W'(gd));
        write_reg(pdsf_pkg::REG_DUTY_LOW,  pdsf_pkg::CFG_DATA_W'(lo));
        write_reg(pdsf_pkg::REG_DUTY_HIGH, pdsf_pkg::CFG_DATA_W'(hi));
        write_reg(pdsf_pkg::REG_DEVICE_ID, pdsf_pkg::CFG_DATA_W'(id));
        write_reg(pdsf_pkg::REG_SERVO,     pdsf_pkg::CFG_DATA_W'(sv));
        i_cfg_valid <= 1'b0;
    endtask

    // drain: every owed byte seen, then room for the pipeline to settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // output side: random stalls plus an optional long forced hold
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every output transfer against the oldest owed byte
    // ------------------------------------------------------------------
    function automatic void compare_field(input string what, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t ns: stray byte, expected none actual tx_byte %0d", $time,
                         o_m_tdata[7:0]);
                mismatch_cnt++;
            end else begin
                want_byte = pending_bytes.pop_front();
                compare_field("tx_byte", want_byte.tx_byte, o_m_tdata[7:0]);
                compare_field("last_byte", want_byte.last_byte, o_m_tlast);
                compare_field("duty_now", want_byte.duty_now, o_m_tdata[21:8]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // power-on gains and bounds, zero error, both full-scale errors and a small negative error
    task automatic test_reset_defaults();
        send_sample(12'd2048, 12'd2048);
        send_sample(12'hFFF, 12'h000);
        send_sample(12'h000, 12'hFFF);
        send_sample(12'd1000, 12'd1200);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        // extreme gains, full duty range; out-of-field bits must be dropped
        load_config(-32768, 32767, -32768, 16'hC000, 16'hFFFF, 16'hFF80 | 127, 127);
        send_sample(12'hFFF, 12'h000);
        send_sample(12'h000, 12'hFFF);
        send_sample(12'd2048, 12'd2048);
        wait_idle();
        // write to an undecoded index: nothing may change
        write_reg(REG_UNUSED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_sample(12'd1, 12'd0);
        wait_idle();
        // crossed bounds: low wins, so the duty flips between the two
        load_config(0, 0, 0, 3000, 2000, 0, 0);
        send_sample(12'd100, 12'd100);
        send_sample(12'd100, 12'd100);
        send_sample(12'd100, 12'd100);
        wait_idle();
        load_config(32767, 0, 32767, 3000, 2000, 0, 0);
        send_sample(12'd2500, 12'd2000);
        send_sample(12'd2000, 12'd2600);
        wait_idle();
    endtask

    // random gains and bounds, then a phase of random samples
    task automatic test_random_phase(input int idle_in, input int stall_out, input int n);
        int gp, gi, gd, lo, hi, k, sp, mv;
        gp = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(8191) - 4096;
        gi = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(255) - 128;
        gd = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(16383) - 4096;
        lo = $urandom_range(4000);
        hi = lo + $urandom_range(8000);
        if ($urandom_range(3) == 0) begin
            lo = $urandom_range(65535);
            hi = $urandom_range(65535);
        end
        load_config(gp, gi, gd, lo, hi, $urandom_range(65535), $urandom_range(65535));
        gap_pct   = idle_in;
        stall_pct = stall_out;
        for (k = 0; k < n; k++) begin
            sp = $urandom_range(4095);
            // half the samples sit near the set point, as a settled loop would
            if ($urandom_range(1) == 0)
                mv = $urandom_range(4095);
            else
                mv = sp + $urandom_range(64) - 32;
            if (mv < 0)
                mv = 0;
            if (mv > 4095)
                mv = 4095;
            send_sample(sp[11:0], mv[11:0]);
        end
        wait_idle();
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    // long output hold while samples keep coming: queue fills, input stalls
    task automatic test_backpressure();
        int k;
        hold_left = 400;
        for (k = 0; k < 24; k++)
            send_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)));
        wait_idle();
    endtask

    // drive the integral hard up at full gain, then back down
    task automatic test_integral_ramp();
        int k;
        load_config(0, 32767, 0, 0, 16383, 85, 42);
        for (k = 0; k < 10; k++)
            send_sample(12'hFFF, 12'h000);
        for (k = 0; k < 10; k++)
            send_sample(12'h000, 12'hFFF);
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_random_phase(0, 0, 40);
        test_random_phase(81, 0, 40);
        test_random_phase(0, 81, 40);
        test_random_phase(38, 38, 40);
        test_backpressure();
        test_integral_ramp();

        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit, well beyond the slowest legal run (under 0.1 ms)
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
hw/rtl/pdsf_pkg.sv
hw/rtl/pdsf_front.sv
hw/rtl/pdsf_fifo.sv
hw/rtl/pdsf_back.sv
hw/rtl/pid_duty_servo_frame.sv
tb/pid_duty_servo_frame_test.sv
